// ===== design/srsw_pkg.sv =====
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and constants of the selective-repeat send window.
// ----------------------------------------------------------------------------
package srsw_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int LIST_DEPTH   = 256;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_CLEAR  = 3'd1,
    CMD_START  = 3'd2,
    CMD_ACK    = 3'd3,
    CMD_GROW   = 3'd4,
    CMD_SHRINK = 3'd5,
    CMD_TICK   = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_SEND   = 2'd1,
    KIND_RESEND = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RMV_RD,
    ST_RMV_USE,
    ST_FILL_START,
    ST_FILL_RD,
    ST_FILL_USE,
    ST_TICK_RD,
    ST_TICK_USE,
    ST_STATUS
  } state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] pkt_id;
    logic [31:0] chunk_id;
    logic [7:0]  amount;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] out_pkt_id;
    logic [31:0] out_chunk_id;
    logic [4:0]  in_flight;
    logic [31:0] first_chunk;
    logic [31:0] final_chunk;
    logic        last;
  } out_t;

endpackage

// ===== design/srsw_ram.sv =====
// ----------------------------------------------------------------------------
// srsw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srsw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/selective_repeat_send_window_unit.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_send_window_unit
// Sender side of a selective-repeat window over a loaded chunk list.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one command
//   transaction: load, clear, start, ack, grow, shrink or tick.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns the
//   result transactions of that command; the final one has last set.
//   Commands are handled one at a time; in_stall_o is high from acceptance
//   until the last result is registered.
//   Steps: load, clear, grow, shrink and unused codes give one status
//   result. A tick reads the window RAM then emits a resend per in-flight
//   entry, or gives a status result when the window is empty. Start reads
//   the list RAM then emits a send and writes the window per new send, and
//   gives a status result when nothing is sent. An ack adds a compaction
//   pass over the in-flight entries before the fill.
//   Status fields are taken from registers.
//   Reset: list and window empty, limit 1; RAM contents are not cleared,
//   only entries below the counts are ever read.
//   Output stall: the sequencer holds in its emit step while a result
//   waits; RAM read data holds since no new read is issued.
// ----------------------------------------------------------------------------
module selective_repeat_send_window_unit #(
  parameter int WINDOW_DEPTH = srsw_pkg::WINDOW_DEPTH,
  parameter int LIST_DEPTH   = srsw_pkg::LIST_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  srsw_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output srsw_pkg::out_t out_data_o
);

  localparam int CW  = $clog2(WINDOW_DEPTH + 1);
  localparam int LW  = $clog2(LIST_DEPTH + 1);
  localparam int WAW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int LAW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int MW  = (CW > LW) ? CW : LW;
  localparam int SW  = ((CW > 8) ? CW : 8) + 1;

  srsw_pkg::state_e state_q, state_d;
  logic [CW-1:0] wc_q, wc_d, lim_q, lim_d, idx_q, idx_d;
  logic [CW-1:0] kept_q, kept_d, rem_q, rem_d, ifl_q, ifl_d;
  logic [LW-1:0] lc_q, lc_d, si_q, si_d;
  logic [31:0]   first_q, first_d, final_q, final_d;
  logic [31:0]   ack_pkt_q, ack_pkt_d, ack_chunk_q, ack_chunk_d;
  logic          out_valid_q, out_valid_d;
  srsw_pkg::out_t out_q, out_d;

  // RAM ports
  logic           win_we, win_re, list_we, list_re;
  logic [WAW-1:0] win_waddr, win_raddr;
  logic [63:0]    win_wdata, win_rdata, list_rdata;

  // fill sizing
  logic [CW-1:0] room, nfill;
  logic [LW-1:0] lst;
  logic [SW-1:0] sum;
  logic          out_free, accept;

  assign in_stall_o  = (state_q != srsw_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    room  = (lim_q > wc_q) ? (lim_q - wc_q) : '0;
    lst   = lc_q - si_q;
    nfill = (MW'(lst) < MW'(room)) ? CW'(lst) : room;
    sum   = SW'(lim_q) + SW'(in_data_i.amount);
  end

  always_comb begin
    state_d     = state_q;
    wc_d        = wc_q;
    lim_d       = lim_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    rem_d       = rem_q;
    ifl_d       = ifl_q;
    lc_d        = lc_q;
    si_d        = si_q;
    first_d     = first_q;
    final_d     = final_q;
    ack_pkt_d   = ack_pkt_q;
    ack_chunk_d = ack_chunk_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    win_we      = 1'b0;
    win_re      = 1'b0;
    list_we     = 1'b0;
    list_re     = 1'b0;
    win_waddr   = wc_q[WAW-1:0];
    win_wdata   = list_rdata;
    win_raddr   = idx_q[WAW-1:0];

    out_d.first_chunk = out_q.first_chunk;
    case (state_q)
      srsw_pkg::ST_IDLE: begin
        if (accept) begin
          idx_d   = '0;
          kept_d  = '0;
          state_d = srsw_pkg::ST_STATUS;
          case (in_data_i.cmd)
            srsw_pkg::CMD_LOAD: begin
              if (lc_q < LW'(LIST_DEPTH)) begin
                list_we = 1'b1;
                lc_d    = lc_q + 1'b1;
                final_d = in_data_i.chunk_id;
                if (lc_q == '0) begin
                  first_d = in_data_i.chunk_id;
                end
              end
            end
            srsw_pkg::CMD_CLEAR: begin
              lc_d = '0;
              si_d = '0;
            end
            srsw_pkg::CMD_START: state_d = srsw_pkg::ST_FILL_START;
            srsw_pkg::CMD_ACK: begin
              ack_pkt_d   = in_data_i.pkt_id;
              ack_chunk_d = in_data_i.chunk_id;
              state_d = (wc_q == '0) ? srsw_pkg::ST_FILL_START : srsw_pkg::ST_RMV_RD;
            end
            srsw_pkg::CMD_GROW: begin
              if (SW'(in_data_i.amount) >= SW'(WINDOW_DEPTH) || sum >= SW'(WINDOW_DEPTH)) begin
                lim_d = CW'(WINDOW_DEPTH);
              end else begin
                lim_d = sum[CW-1:0];
              end
            end
            srsw_pkg::CMD_SHRINK: begin
              if (SW'(in_data_i.amount) >= SW'(lim_q)) begin
                lim_d = CW'(1);
              end else begin
                lim_d = lim_q - CW'(in_data_i.amount);
              end
            end
            srsw_pkg::CMD_TICK: begin
              if (wc_q != '0) begin
                state_d = srsw_pkg::ST_TICK_RD;
              end
            end
            default: ;
          endcase
        end
      end
      srsw_pkg::ST_RMV_RD: begin
        win_re  = 1'b1;
        state_d = srsw_pkg::ST_RMV_USE;
      end
      srsw_pkg::ST_RMV_USE: begin
        // compaction: survivors move down to kept; kept never passes the read index
        if (!(win_rdata[63:32] == ack_pkt_q && win_rdata[31:0] == ack_chunk_q)) begin
          win_we    = 1'b1;
          win_waddr = kept_q[WAW-1:0];
          win_wdata = win_rdata;
          kept_d    = kept_q + 1'b1;
        end
        idx_d = idx_q + 1'b1;
        if (idx_q + 1'b1 == wc_q) begin
          wc_d    = kept_d;
          state_d = srsw_pkg::ST_FILL_START;
        end else begin
          state_d = srsw_pkg::ST_RMV_RD;
        end
      end
      srsw_pkg::ST_FILL_START: begin
        rem_d   = nfill;
        ifl_d   = wc_q + nfill;
        state_d = (nfill == '0) ? srsw_pkg::ST_STATUS : srsw_pkg::ST_FILL_RD;
      end
      srsw_pkg::ST_FILL_RD: begin
        list_re = 1'b1;
        state_d = srsw_pkg::ST_FILL_USE;
      end
      srsw_pkg::ST_FILL_USE: begin
        if (out_free) begin
          win_we             = 1'b1;
          out_valid_d        = 1'b1;
          out_d.kind         = srsw_pkg::KIND_SEND;
          out_d.out_pkt_id   = list_rdata[63:32];
          out_d.out_chunk_id = list_rdata[31:0];
          out_d.in_flight    = 5'(ifl_q);
          out_d.last         = (rem_q == CW'(1));
          wc_d               = wc_q + 1'b1;
          si_d               = si_q + 1'b1;
          rem_d              = rem_q - 1'b1;
          state_d = (rem_q == CW'(1)) ? srsw_pkg::ST_IDLE : srsw_pkg::ST_FILL_RD;
        end
      end
      srsw_pkg::ST_TICK_RD: begin
        win_re  = 1'b1;
        state_d = srsw_pkg::ST_TICK_USE;
      end
      srsw_pkg::ST_TICK_USE: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.kind         = srsw_pkg::KIND_RESEND;
          out_d.out_pkt_id   = win_rdata[63:32];
          out_d.out_chunk_id = win_rdata[31:0];
          out_d.in_flight    = 5'(wc_q);
          out_d.last         = (idx_q + 1'b1 == wc_q);
          idx_d              = idx_q + 1'b1;
          state_d = (idx_q + 1'b1 == wc_q) ? srsw_pkg::ST_IDLE : srsw_pkg::ST_TICK_RD;
        end
      end
      srsw_pkg::ST_STATUS: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.kind         = srsw_pkg::KIND_STATUS;
          out_d.out_pkt_id   = '0;
          out_d.out_chunk_id = '0;
          out_d.in_flight    = 5'(wc_q);
          out_d.last         = 1'b1;
          state_d            = srsw_pkg::ST_IDLE;
        end
      end
      default: state_d = srsw_pkg::ST_IDLE;
    endcase

    // list-end status comes straight from the tracked registers
    if (out_valid_d && !(out_valid_q && out_stall_i)) begin
      out_d.first_chunk = (lc_d == '0) ? '0 : first_d;
      out_d.final_chunk = (lc_d == '0) ? '0 : final_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srsw_pkg::ST_IDLE;
      wc_q        <= '0;
      lim_q       <= CW'(1);
      lc_q        <= '0;
      si_q        <= '0;
      idx_q       <= '0;
      kept_q      <= '0;
      rem_q       <= '0;
      ifl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wc_q        <= wc_d;
      lim_q       <= lim_d;
      lc_q        <= lc_d;
      si_q        <= si_d;
      idx_q       <= idx_d;
      kept_q      <= kept_d;
      rem_q       <= rem_d;
      ifl_q       <= ifl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q     <= first_d;
    final_q     <= final_d;
    ack_pkt_q   <= ack_pkt_d;
    ack_chunk_q <= ack_chunk_d;
    out_q       <= out_d;
  end

  srsw_ram #(
    .WIDTH(64),
    .DEPTH(LIST_DEPTH)
  ) u_list_ram (
    .clk_i  (clk_i),
    .we_i   (list_we),
    .waddr_i(lc_q[LAW-1:0]),
    .wdata_i({in_data_i.pkt_id, in_data_i.chunk_id}),
    .re_i   (list_re),
    .raddr_i(si_q[LAW-1:0]),
    .rdata_o(list_rdata)
  );

  srsw_ram #(
    .WIDTH(64),
    .DEPTH(WINDOW_DEPTH)
  ) u_win_ram (
    .clk_i  (clk_i),
    .we_i   (win_we),
    .waddr_i(win_waddr),
    .wdata_i(win_wdata),
    .re_i   (win_re),
    .raddr_i(win_raddr),
    .rdata_o(win_rdata)
  );

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Bench for the selective-repeat send window: a directed table, a full-list run,
// then random load/start/ack/grow/shrink/tick/clear traffic checked against an in-bench window predictor.
// ----------------------------------------------------------------------------
module tb_top;

  // command code with no meaning; must give one status result
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o;
  srsw_pkg::in_t  in_data_i = '0;
  srsw_pkg::out_t out_data_o;

  selective_repeat_send_window_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: chunk list, in-flight window and limit.
  logic [31:0] lst_pkt [srsw_pkg::LIST_DEPTH];
  logic [31:0] lst_chk [srsw_pkg::LIST_DEPTH];
  int unsigned lst_cnt, snd_idx;
  logic [31:0] win_pkt [srsw_pkg::WINDOW_DEPTH];
  logic [31:0] win_chk [srsw_pkg::WINDOW_DEPTH];
  int unsigned win_cnt, win_lim;

  srsw_pkg::out_t pending_results[$];
  int   errors, accepted, checked, sends, resends;
  int   send_idle, recv_idle; // percent

  // Tracks recently loaded ids so acks can hit in-flight entries.
  logic [31:0] pool_pkt[$];
  logic [31:0] pool_chk[$];

  task automatic report(input string what, input srsw_pkg::out_t got,
                        input srsw_pkg::out_t exp);
    $display("mismatch %s: got %h expected %h", what, got, exp);
    errors++;
  endtask

  // Appends the sends of a window fill to the list of produced results.
  task automatic fill_window(inout srsw_pkg::out_t res[$]);
    srsw_pkg::out_t r;
    while (win_cnt < win_lim && win_cnt < srsw_pkg::WINDOW_DEPTH && snd_idx < lst_cnt) begin
      r = '0;
      r.kind = srsw_pkg::KIND_SEND;
      r.out_pkt_id = lst_pkt[snd_idx];
      r.out_chunk_id = lst_chk[snd_idx];
      win_pkt[win_cnt] = lst_pkt[snd_idx];
      win_chk[win_cnt] = lst_chk[snd_idx];
      snd_idx++;
      win_cnt++;
      res = {res, r};
    end
  endtask

  task automatic predict_window(input srsw_pkg::in_t t);
    srsw_pkg::out_t res[$];
    srsw_pkg::out_t r;
    int unsigned kept;
    case (t.cmd)
      srsw_pkg::CMD_LOAD: if (lst_cnt < srsw_pkg::LIST_DEPTH) begin
        lst_pkt[lst_cnt] = t.pkt_id;
        lst_chk[lst_cnt] = t.chunk_id;
        lst_cnt++;
      end
      srsw_pkg::CMD_CLEAR: begin
        lst_cnt = 0;
        snd_idx = 0;
      end
      srsw_pkg::CMD_START: fill_window(res);
      srsw_pkg::CMD_ACK: begin
        kept = 0;
        for (int i = 0; i < win_cnt; i++)
          if (!(win_pkt[i] == t.pkt_id && win_chk[i] == t.chunk_id)) begin
            win_pkt[kept] = win_pkt[i];
            win_chk[kept] = win_chk[i];
            kept++;
          end
        win_cnt = kept;
        fill_window(res);
      end
      srsw_pkg::CMD_GROW:
        win_lim = (win_lim + t.amount >= srsw_pkg::WINDOW_DEPTH) ? srsw_pkg::WINDOW_DEPTH
                                                                 : win_lim + t.amount;
      srsw_pkg::CMD_SHRINK: win_lim = (t.amount >= win_lim) ? 1 : win_lim - t.amount;
      srsw_pkg::CMD_TICK: for (int i = 0; i < win_cnt; i++) begin
        r = '0;
        r.kind = srsw_pkg::KIND_RESEND;
        r.out_pkt_id = win_pkt[i];
        r.out_chunk_id = win_chk[i];
        res = {res, r};
      end
      default: ;
    endcase
    if (res.size() == 0) begin
      r = '0;
      res = {res, r};
    end
    foreach (res[k]) begin
      res[k].in_flight = win_cnt[4:0];
      res[k].first_chunk = lst_cnt ? lst_chk[0] : '0;
      res[k].final_chunk = lst_cnt ? lst_chk[lst_cnt - 1] : '0;
      res[k].last = (k == res.size() - 1);
      pending_results = {pending_results, res[k]};
    end
  endtask

  // Drives one command; waits for acceptance. Valid stays high across
  // back-to-back transactions (single NBA per step).
  task automatic send_cmd(input srsw_pkg::in_t t);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    predict_window(t);
    accepted++;
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic srsw_pkg::in_t mk(input logic [2:0] c, input logic [31:0] p,
                                       input logic [31:0] ch, input logic [7:0] a);
    srsw_pkg::in_t t;
    t.cmd = c; t.pkt_id = p; t.chunk_id = ch; t.amount = a;
    return t;
  endfunction

  // Receiver: random stall, compare every accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) report("unexpected", out_data_o, '0);
        else begin
          if (out_data_o !== pending_results[0])
            report("result", out_data_o, pending_results[0]);
          void'(pending_results.pop_front());
          checked++;
          if (out_data_o.kind == srsw_pkg::KIND_SEND) sends++;
          if (out_data_o.kind == srsw_pkg::KIND_RESEND) resends++;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic drain();
    go_idle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // Directed table; exp_on marks rows whose single status result is fixed.
  typedef struct {
    srsw_pkg::in_t  t;
    bit             exp_on;
    srsw_pkg::out_t exp;
  } row_t;

  row_t dir_rows[$];

  task automatic add_row(input srsw_pkg::in_t t);
    row_t r;
    r.t = t; r.exp_on = 0; r.exp = '0;
    dir_rows = {dir_rows, r};
  endtask

  task automatic add_fixed(input srsw_pkg::in_t t, input srsw_pkg::out_t e);
    row_t r;
    r.t = t; r.exp_on = 1; r.exp = e;
    dir_rows = {dir_rows, r};
  endtask

  task automatic random_phase(input int n);
    srsw_pkg::in_t t;
    int  sel, k;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      t = mk(srsw_pkg::CMD_LOAD, $urandom, $urandom, 8'($urandom));
      if (sel < 40) begin
        if ($urandom_range(3) == 0) t.pkt_id = pool_pkt.size() ? pool_pkt[0] : t.pkt_id;
        pool_pkt = {pool_pkt, t.pkt_id};
        pool_chk = {pool_chk, t.chunk_id};
        if (pool_pkt.size() > 40) begin
          void'(pool_pkt.pop_front());
          void'(pool_chk.pop_front());
        end
      end else if (sel < 50) t.cmd = srsw_pkg::CMD_START;
      else if (sel < 72) begin
        t.cmd = srsw_pkg::CMD_ACK;
        if (pool_pkt.size() && $urandom_range(9) < 8) begin
          k = $urandom_range(pool_pkt.size() - 1);
          t.pkt_id = pool_pkt[k];
          t.chunk_id = ($urandom_range(9) == 0) ? $urandom : pool_chk[k];
        end
      end else if (sel < 80) begin
        t.cmd = srsw_pkg::CMD_GROW;
        t.amount = $urandom_range(1) ? 8'($urandom_range(4)) : 8'($urandom);
      end else if (sel < 86) begin
        t.cmd = srsw_pkg::CMD_SHRINK;
        t.amount = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
      end else if (sel < 96) t.cmd = srsw_pkg::CMD_TICK;
      else if (sel < 98) t.cmd = srsw_pkg::CMD_CLEAR;
      else t.cmd = CMD_UNUSED;
      send_cmd(t);
    end
  endtask

  initial begin
    srsw_pkg::out_t e;
    lst_cnt = 0; snd_idx = 0; win_cnt = 0; win_lim = 1;
    errors = 0; accepted = 0; checked = 0; sends = 0; resends = 0;
    send_idle = 19; recv_idle = 55;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty status after reset, id extremes, limit saturation and
    // floor, ack of duplicates, limit below occupancy, unused code, full list.
    e = '0; e.last = 1'b1;
    add_fixed(mk(srsw_pkg::CMD_TICK, '0, '0, '0), e);
    add_fixed(mk(srsw_pkg::CMD_START, '0, '0, '0), e);
    add_fixed(mk(CMD_UNUSED, '1, '1, '1), e);
    add_row(mk(srsw_pkg::CMD_LOAD, '0, '0, 8'd0));
    add_row(mk(srsw_pkg::CMD_LOAD, '1, '1, 8'hff));
    add_row(mk(srsw_pkg::CMD_LOAD, 32'h5, 32'h7, 8'd0));
    add_row(mk(srsw_pkg::CMD_LOAD, 32'h5, 32'h7, 8'd0));
    add_row(mk(srsw_pkg::CMD_LOAD, 32'haaaa5555, 32'h5555aaaa, 8'd0));
    add_row(mk(srsw_pkg::CMD_START, '0, '0, '0));
    add_row(mk(srsw_pkg::CMD_GROW, '0, '0, 8'd255));
    add_row(mk(srsw_pkg::CMD_START, '0, '0, '0));
    add_row(mk(srsw_pkg::CMD_TICK, '0, '0, '0));
    add_row(mk(srsw_pkg::CMD_ACK, 32'h5, 32'h7, '0));
    add_row(mk(srsw_pkg::CMD_ACK, '1, '1, '0));
    add_row(mk(srsw_pkg::CMD_SHRINK, '0, '0, 8'd255));
    add_row(mk(srsw_pkg::CMD_CLEAR, '0, '0, '0));
    add_row(mk(srsw_pkg::CMD_TICK, '0, '0, '0));
    add_row(mk(srsw_pkg::CMD_GROW, '0, '0, 8'd3));
    add_row(mk(srsw_pkg::CMD_SHRINK, '0, '0, 8'd1));
    add_row(mk(srsw_pkg::CMD_ACK, '0, '0, '0));
    add_row(mk(srsw_pkg::CMD_ACK, 32'haaaa5555, 32'h5555aaaa, '0));
    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].t);
      // fixed expectation must agree with the predicted one
      if (dir_rows[i].exp_on && pending_results[$] !== dir_rows[i].exp)
        report("table", pending_results[$], dir_rows[i].exp);
    end
    drain();

    // Fill the list to capacity, then one more load that must be ignored.
    for (int i = 0; i <= srsw_pkg::LIST_DEPTH; i++)
      send_cmd(mk(srsw_pkg::CMD_LOAD, $urandom, $urandom, 8'($urandom)));
    send_cmd(mk(srsw_pkg::CMD_GROW, '0, '0, 8'd16));
    send_cmd(mk(srsw_pkg::CMD_START, '0, '0, '0));
    send_cmd(mk(srsw_pkg::CMD_TICK, '0, '0, '0));
    send_cmd(mk(srsw_pkg::CMD_CLEAR, '0, '0, '0));
    drain(); // sender holds off until every result has come

    random_phase(14);
    drain();
    send_idle = 55; recv_idle = 19;
    random_phase(14);
    drain();
    send_idle = 0; recv_idle = 0;
    random_phase(14);
    drain();

    $display("covered %0d commands, %0d results (%0d sends, %0d resends)",
             accepted, checked, sends, resends);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
